// ----- rtl/mpwv_pkg.sv -----
// Package with the phase codes, limits, domain tag and shared types of the proof validator.
package mpwv_pkg;

  localparam int unsigned WireMax     = 262144;
  localparam int unsigned MaxLevels   = 64;
  localparam int unsigned MaxChildren = 4096;
  localparam int unsigned PathCap     = 256;
  localparam int unsigned NameCap     = 256;
  localparam int unsigned KindMax     = 1;
  localparam int unsigned DomainLen   = 30;
  localparam int unsigned DigestLen   = 32;

  typedef enum logic [3:0] {
    PH_DOMAIN = 4'd0,
    PH_KIND   = 4'd1,
    PH_PLEN   = 4'd2,
    PH_PBYTE  = 4'd3,
    PH_LEVELS = 4'd4,
    PH_TOTAL  = 4'd5,
    PH_LPLEN  = 4'd6,
    PH_LPBYTE = 4'd7,
    PH_COUNT  = 4'd8,
    PH_INDEX  = 4'd9,
    PH_CKIND  = 4'd10,
    PH_CNLEN  = 4'd11,
    PH_CNBYTE = 4'd12,
    PH_DIGEST = 4'd13,
    PH_EXCESS = 4'd14
  } phase_e;

  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_REJECTED = 2'd2
  } status_e;

  localparam logic [7:0] DOMAIN_TAG [DomainLen] = '{
    8'h7a, 8'h63, 8'h6c, 8'h2e, 8'h63, 8'h6f, 8'h64, 8'h65, 8'h69, 8'h6e,
    8'h64, 8'h65, 8'h78, 8'h2e, 8'h6d, 8'h65, 8'h72, 8'h6b, 8'h6c, 8'h65,
    8'h2e, 8'h70, 8'h72, 8'h6f, 8'h6f, 8'h66, 8'h2e, 8'h76, 8'h31, 8'h00
  };

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  field_counter;
    logic [31:0] assembly_word;
    logic [18:0] message_bytes;
    logic [6:0]  levels_declared;
    logic [12:0] children_declared;
    logic [6:0]  current_level;
    logic [12:0] children_run;
    logic [12:0] level_child_count;
    logic [12:0] child_in_level;
    logic [15:0] string_length;
    logic        rejected;
  } state_t;

  typedef struct packed {
    logic [3:0]  field_class;
    logic [7:0]  byte_value;
    logic [5:0]  level_number;
    logic [11:0] child_number;
    logic [7:0]  field_offset;
    logic        field_complete;
    logic [1:0]  status;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase: PH_DOMAIN, field_counter: '0, assembly_word: '0, message_bytes: '0,
    levels_declared: '0, children_declared: '0, current_level: '0,
    children_run: '0, level_child_count: '0, child_in_level: '0,
    string_length: '0, rejected: 1'b0
  };

endpackage

// ----- rtl/mpwv_if.sv -----
// Byte input and result output channel interfaces of the proof validator.
interface mpwv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;
  modport source (output valid, in_byte, last_byte, input ready);
  modport sink (input valid, in_byte, last_byte, output ready);
endinterface

interface mpwv_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_class;
  logic [7:0]  byte_value;
  logic [5:0]  level_number;
  logic [11:0] child_number;
  logic [7:0]  field_offset;
  logic        field_complete;
  logic [1:0]  status;
  modport source (output valid, field_class, byte_value, level_number, child_number,
                  field_offset, field_complete, status, input ready);
  modport sink (input valid, field_class, byte_value, level_number, child_number,
                field_offset, field_complete, status, output ready);
endinterface

// ----- rtl/merkle_proof_wire_validator_unit.sv -----
// Top level of the proof validator: input register, parse step and result register.
//
//   channel | dir | payload
//   in_i    | in  | in_byte, last_byte
//   out_o   | out | field_class, byte_value, level_number, child_number,
//           |     | field_offset, field_complete, status
//
// Each byte passes the input register and then the parse step, which writes the
// result register; one byte per cycle is sustained while out_o is not stalled.
// Reset returns the parser to the start of a message.
// A stalled result holds the parse step; the input register still takes one byte.
module merkle_proof_wire_validator_unit import mpwv_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  mpwv_in_if.sink     in_i,
  mpwv_out_if.source  out_o
);

  logic       a_valid_q;
  logic [7:0] a_byte_q;
  logic       a_last_q;
  logic       o_valid_q;
  result_t    res_q;
  result_t    res_d;
  state_t     state_q;
  state_t     state_d;
  logic       advance;

  assign advance     = a_valid_q && (!o_valid_q || out_o.ready);
  assign in_i.ready  = !a_valid_q || advance;

  mpwv_step u_step (
    .state_i  (state_q),
    .byte_i   (a_byte_q),
    .last_i   (a_last_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
      state_q   <= STATE_RESET;
    end else begin
      if (in_i.ready) begin
        a_valid_q <= in_i.valid;
      end
      if (advance) begin
        o_valid_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_o.ready) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      a_byte_q <= in_i.in_byte;
      a_last_q <= in_i.last_byte;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = o_valid_q;
  assign out_o.field_class    = res_q.field_class;
  assign out_o.byte_value     = res_q.byte_value;
  assign out_o.level_number   = res_q.level_number;
  assign out_o.child_number   = res_q.child_number;
  assign out_o.field_offset   = res_q.field_offset;
  assign out_o.field_complete = res_q.field_complete;
  assign out_o.status         = res_q.status;

endmodule

// ----- rtl/mpwv_step.sv -----
// Combinational per-byte parse step: next parser state and the tagged result.
module mpwv_step import mpwv_pkg::*; (
  input  state_t     state_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output state_t     state_o,
  output result_t    result_o
);

  state_t      s;
  state_t      n;
  logic        bad;
  logic        done;
  logic [3:0]  cls;
  logic [31:0] gword;
  logic [8:0]  fc_inc;
  logic [18:0] mb_inc;
  logic [12:0] cil_inc;
  logic [12:0] cr_inc;
  logic [6:0]  cl_inc;
  logic        in_levels;

  assign s = state_i;

  always_comb begin
    n         = s;
    bad       = 1'b0;
    done      = 1'b0;
    cls       = 4'(PH_EXCESS);
    fc_inc    = {1'b0, s.field_counter} + 9'd1;
    gword     = s.assembly_word | ({24'd0, byte_i} << {s.field_counter[1:0], 3'b000});
    cil_inc   = s.child_in_level + 13'd1;
    cr_inc    = s.children_run + 13'd1;
    cl_inc    = s.current_level + 7'd1;
    mb_inc    = s.message_bytes;
    in_levels = (s.phase >= PH_LPLEN) && (s.phase <= PH_DIGEST);

    if (mb_inc <= 19'(WireMax)) begin
      mb_inc = mb_inc + 19'd1;
    end
    if (mb_inc > 19'(WireMax)) begin
      bad = 1'b1;
    end
    n.message_bytes = mb_inc;

    case (s.phase)
      PH_DOMAIN: begin
        cls = 4'(PH_DOMAIN);
        if (s.field_counter >= 8'(DomainLen) || byte_i != DOMAIN_TAG[s.field_counter[4:0]]) begin
          bad = 1'b1;
        end
        if (fc_inc >= 9'(DomainLen)) begin
          done = 1'b1;
          n.phase = PH_KIND; n.field_counter = '0; n.assembly_word = '0;
        end else begin
          n.field_counter = fc_inc[7:0];
        end
      end
      PH_KIND, PH_CKIND: begin
        cls  = 4'(s.phase);
        done = 1'b1;
        if (byte_i > 8'(KindMax)) begin
          bad = 1'b1;
        end
        n.phase = (s.phase == PH_KIND) ? PH_PLEN : PH_CNLEN;
        n.field_counter = '0; n.assembly_word = '0;
      end
      PH_PLEN, PH_LPLEN, PH_CNLEN: begin
        cls = 4'(s.phase);
        if (fc_inc >= 9'd2) begin
          done = 1'b1;
          n.string_length = gword[15:0];
          if (gword[15:0] >= ((s.phase == PH_CNLEN) ? 16'(NameCap) : 16'(PathCap))) begin
            bad = 1'b1;
          end
          n.field_counter = '0; n.assembly_word = '0;
          if (gword[15:0] != 16'd0) begin
            n.phase = phase_e'(s.phase + 4'd1);
          end else if (s.phase == PH_PLEN) begin
            n.phase = PH_LEVELS;
          end else if (s.phase == PH_LPLEN) begin
            n.phase = PH_COUNT;
          end else begin
            n.phase = PH_DIGEST;
          end
        end else begin
          n.field_counter = fc_inc[7:0];
          n.assembly_word = gword;
        end
      end
      PH_PBYTE, PH_LPBYTE, PH_CNBYTE: begin
        cls = 4'(s.phase);
        if (byte_i == 8'd0) begin
          bad = 1'b1;
        end
        n.field_counter = fc_inc[7:0];
        if ({7'd0, fc_inc} >= s.string_length) begin
          done = 1'b1;
          n.field_counter = '0; n.assembly_word = '0;
          if (s.phase == PH_PBYTE) begin
            n.phase = PH_LEVELS;
          end else if (s.phase == PH_LPBYTE) begin
            n.phase = PH_COUNT;
          end else begin
            n.phase = PH_DIGEST;
          end
        end
      end
      PH_LEVELS, PH_TOTAL, PH_COUNT, PH_INDEX: begin
        cls = 4'(s.phase);
        if (fc_inc >= 9'd4) begin
          done = 1'b1;
          n.field_counter = '0; n.assembly_word = '0;
          case (s.phase)
            PH_LEVELS: begin
              if (gword > 32'(MaxLevels)) begin
                bad = 1'b1;
              end else begin
                n.levels_declared = gword[6:0];
              end
              n.phase = PH_TOTAL;
            end
            PH_TOTAL: begin
              if (gword > 32'(MaxChildren)) begin
                bad = 1'b1;
              end else begin
                n.children_declared = gword[12:0];
              end
              if (s.levels_declared == 7'd0) begin
                if (n.children_declared != 13'd0) begin
                  bad = 1'b1;
                end
                n.phase = PH_EXCESS;
              end else begin
                n.phase = PH_LPLEN;
              end
            end
            PH_COUNT: begin
              if (gword == 32'd0 || s.children_run > s.children_declared ||
                  gword > {19'd0, s.children_declared - s.children_run}) begin
                bad = 1'b1;
              end else begin
                n.level_child_count = gword[12:0];
              end
              n.phase = PH_INDEX;
            end
            default: begin
              if (gword >= {19'd0, s.level_child_count}) begin
                bad = 1'b1;
              end
              n.child_in_level = '0;
              n.phase = PH_CKIND;
            end
          endcase
        end else begin
          n.field_counter = fc_inc[7:0];
          n.assembly_word = gword;
        end
      end
      PH_DIGEST: begin
        cls = 4'(PH_DIGEST);
        if (fc_inc >= 9'(DigestLen)) begin
          done = 1'b1;
          n.child_in_level = cil_inc;
          n.children_run   = cr_inc;
          n.field_counter = '0; n.assembly_word = '0;
          if (cil_inc >= s.level_child_count) begin
            n.current_level = cl_inc;
            if (cl_inc >= s.levels_declared) begin
              if (cr_inc != s.children_declared) begin
                bad = 1'b1;
              end
              n.phase = PH_EXCESS;
            end else begin
              n.phase = PH_LPLEN;
            end
          end else begin
            n.phase = PH_CKIND;
          end
        end else begin
          n.field_counter = fc_inc[7:0];
        end
      end
      default: begin
        cls = 4'(PH_EXCESS);
        bad = 1'b1;
        n.phase = PH_EXCESS;
        n.field_counter = '0;
      end
    endcase

    if (bad) begin
      n.rejected = 1'b1;
      n.phase = PH_EXCESS;
      n.field_counter = '0;
      n.assembly_word = '0;
    end

    result_o.field_class    = cls;
    result_o.byte_value     = byte_i;
    result_o.level_number   = in_levels ? s.current_level[5:0] : 6'd0;
    result_o.child_number   = in_levels ? s.children_run[11:0] : 12'd0;
    result_o.field_offset   = (s.phase == PH_EXCESS || s.phase > PH_EXCESS) ? 8'd0
                                                                          : s.field_counter;
    result_o.field_complete = done;
    if (last_i) begin
      result_o.status = (!n.rejected && n.phase == PH_EXCESS) ? ST_ACCEPTED : ST_REJECTED;
      state_o = STATE_RESET;
    end else begin
      result_o.status = n.rejected ? ST_REJECTED : ST_VALID;
      state_o = n;
    end
  end

endmodule
